// ----- rtl/srhp_pkg.sv -----
// ----------------------------------------------------------------------------
// srhp_pkg: shared definitions for the source-route hop path
// Operation codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package srhp_pkg;

  localparam int HOP_W   = 8;
  localparam int OP_W    = 3;
  localparam int INDEX_W = 4;
  localparam int PLEN_W  = 5;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_SHIFT   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd5;

  localparam logic CFG_MIN_HOP = 1'b0;
  localparam logic CFG_MAX_HOP = 1'b1;

  localparam logic [HOP_W-1:0] MIN_HOP_RESET = 8'd1;
  localparam logic [HOP_W-1:0] MAX_HOP_RESET = 8'd255;

  // Control decoded for one slot of the chain.
  typedef struct packed {
    logic clear;       // slot goes to zero
    logic take_load;   // slot takes its staged load byte (commit)
    logic write_new;   // slot takes the incoming hop
    logic take_left;   // slot takes its left neighbor (prepend)
    logic take_right;  // slot takes its right neighbor (shift)
    logic load_wr;     // staged load byte is written from the incoming hop
  } cell_ctrl_t;

endpackage

// ----- rtl/srhp_if.sv -----
// ----------------------------------------------------------------------------
// srhp_if: valid/ready channels of the source-route hop path
// One interface for the command words and one for the status words.
// ----------------------------------------------------------------------------
interface srhp_in_if import srhp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [HOP_W-1:0]   hop_in;
  logic [INDEX_W-1:0] hop_index;
  logic               last_item;

  modport source (output valid, op, hop_in, hop_index, last_item, input ready);
  modport sink   (input valid, op, hop_in, hop_index, last_item, output ready);
endinterface

interface srhp_out_if import srhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [HOP_W-1:0]  hop_out;
  logic [PLEN_W-1:0] path_length;
  logic              is_empty;
  logic              is_full;
  logic [HOP_W-1:0]  first_hop;

  modport source (output valid, ok, hop_out, path_length, is_empty, is_full, first_hop,
                  input ready);
  modport sink   (input valid, ok, hop_out, path_length, is_empty, is_full, first_hop,
                  output ready);
endinterface

// ----- rtl/source_route_hop_path_top.sv -----
// ----------------------------------------------------------------------------
// source_route_hop_path_top: source-route path of up to MAX_DEPTH hops
// Status: a status word is registered and shown in the cycle after its command word is taken.
// Throughput: one word per cycle while status words are taken; every op finishes in the single update of the chain.
// Reset (rst, synchronous): path empty, load idle, min_hop 1, max_hop 255.
// ----------------------------------------------------------------------------
module source_route_hop_path_top import srhp_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  srhp_in_if.sink          in_ch,
  srhp_out_if.source       out_ch,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [HOP_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH = LW'(MAX_DEPTH);

  // Configuration registers.
  logic [HOP_W-1:0] min_hop;
  logic [HOP_W-1:0] max_hop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_hop <= MIN_HOP_RESET;
      max_hop <= MAX_HOP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MIN_HOP: min_hop <= cfg_data;
        CFG_MAX_HOP: max_hop <= cfg_data;
        default: ;
      endcase
    end
  end

  // Path length and load sequence state. The hop values themselves live in
  // the chain of cells below; every slot at or past the length holds zero.
  logic [LW-1:0] len;
  logic [LW-1:0] len_next;
  logic [LW-1:0] load_count;
  logic [LW-1:0] load_count_next;
  logic          load_failed;
  logic          load_failed_next;

  logic accept;
  logic legal;
  logic do_append;
  logic do_prepend;
  logic do_shift;
  logic do_clear;
  logic is_load;
  logic load_fail_now;
  logic load_fail_seq;
  logic load_commit;
  logic [LW-1:0] commit_count;
  logic ok_next;

  // The output register frees the input side as soon as its word is taken.
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign legal = (in_ch.hop_in >= min_hop) && (in_ch.hop_in <= max_hop);

  assign do_append  = accept && (in_ch.op == OP_APPEND) && (len < DEPTH) && legal;
  assign do_prepend = accept && (in_ch.op == OP_PREPEND) && (len < DEPTH) && legal;
  assign do_shift   = accept && (in_ch.op == OP_SHIFT) && (len != '0);
  assign do_clear   = accept && (in_ch.op == OP_CLEAR);
  assign is_load    = accept && (in_ch.op == OP_LOAD);

  // A load byte fails when the staging slots are used up or the hop is illegal;
  // a failure sticks until the last byte of the sequence.
  assign load_fail_now = (load_count >= DEPTH) || !legal;
  assign load_fail_seq = load_failed || load_fail_now;
  assign load_commit   = is_load && in_ch.last_item;
  assign commit_count  = load_fail_now ? load_count : load_count + LW'(1);

  always_comb begin
    len_next         = len;
    load_count_next  = load_count;
    load_failed_next = load_failed;
    if (do_append || do_prepend) begin
      len_next = len + LW'(1);
    end else if (do_shift) begin
      len_next = len - LW'(1);
    end else if (do_clear) begin
      len_next = '0;
    end else if (is_load) begin
      if (in_ch.last_item) begin
        len_next         = load_fail_seq ? '0 : commit_count;
        load_count_next  = '0;
        load_failed_next = 1'b0;
      end else begin
        load_count_next  = commit_count;
        load_failed_next = load_fail_seq;
      end
    end
  end

  always_comb begin
    unique case (in_ch.op)
      OP_APPEND:  ok_next = do_append;
      OP_PREPEND: ok_next = do_prepend;
      OP_SHIFT:   ok_next = do_shift;
      OP_CLEAR:   ok_next = 1'b1;
      OP_READ:    ok_next = 1'b1;
      OP_LOAD:    ok_next = !load_fail_seq;
      default:    ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      load_count  <= '0;
      load_failed <= 1'b0;
    end else if (accept) begin
      len         <= len_next;
      load_count  <= load_count_next;
      load_failed <= load_failed_next;
    end
  end

  // Chain of cells. Each slot decodes its own action from the broadcast
  // operation and its position relative to the length or the load count:
  // prepend moves every slot one place right, shift one place left, and a
  // commit copies each slot's staged byte in place.
  logic [HOP_W-1:0] hops      [MAX_DEPTH];
  logic [HOP_W-1:0] hops_next [MAX_DEPTH];

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    localparam logic [LW-1:0] IDX = LW'(g);

    cell_ctrl_t       ctl;
    logic [HOP_W-1:0] left_hop;
    logic [HOP_W-1:0] right_hop;

    always_comb begin
      ctl.write_new  = (do_append && (IDX == len)) || (do_prepend && (IDX == '0));
      ctl.take_left  = do_prepend && (IDX != '0);
      ctl.take_right = do_shift;
      ctl.load_wr    = is_load && !load_fail_now && (IDX == load_count);
      ctl.take_load  = load_commit && !load_fail_seq && (IDX < commit_count);
      ctl.clear      = do_clear ||
                       (load_commit && (load_fail_seq || (IDX >= commit_count)));
    end

    if (g == 0) begin : g_first
      assign left_hop = '0;
    end else begin : g_mid
      assign left_hop = hops[g-1];
    end

    if (g == MAX_DEPTH - 1) begin : g_last
      assign right_hop = '0;
    end else begin : g_inner
      assign right_hop = hops[g+1];
    end

    srhp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .hop_in    (in_ch.hop_in),
      .left_hop  (left_hop),
      .right_hop (right_hop),
      .hop       (hops[g]),
      .hop_next  (hops_next[g])
    );
  end

  // Read of one slot; a read leaves the path unchanged, so the current
  // contents are the contents after the word.
  logic [HOP_W-1:0] read_hop;

  always_comb begin
    read_hop = '0;
    if (in_ch.op == OP_READ) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if ((int'(in_ch.hop_index) == i) && (LW'(i) < len)) begin
          read_hop = hops[i];
        end
      end
    end
  end

  // The status field is five bits wide whatever the depth; widen first so the
  // low bits can be picked for any length width.
  logic [LW+PLEN_W-1:0] len_wide;
  assign len_wide = {{PLEN_W{1'b0}}, len_next};

  // Output register holding the status word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.ok          <= ok_next;
      out_ch.hop_out     <= read_hop;
      out_ch.path_length <= len_wide[PLEN_W-1:0];
      out_ch.is_empty    <= (len_next == '0);
      out_ch.is_full     <= (len_next >= DEPTH);
      out_ch.first_hop   <= hops_next[0];
    end
  end

endmodule

// ----- rtl/srhp_cell.sv -----
// ----------------------------------------------------------------------------
// srhp_cell: one slot of the hop chain
// Holds one path hop and one staged load byte, exchanging with its neighbors.
// ----------------------------------------------------------------------------
module srhp_cell import srhp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctl,
  input  logic [HOP_W-1:0] hop_in,
  input  logic [HOP_W-1:0] left_hop,
  input  logic [HOP_W-1:0] right_hop,
  output logic [HOP_W-1:0] hop,
  output logic [HOP_W-1:0] hop_next
);

  logic [HOP_W-1:0] load_hop;
  logic [HOP_W-1:0] load_val;

  // The byte written in the same cycle as a commit is taken straight from the input.
  assign load_val = ctl.load_wr ? hop_in : load_hop;

  always_comb begin
    priority if (ctl.clear) begin
      hop_next = '0;
    end else if (ctl.take_load) begin
      hop_next = load_val;
    end else if (ctl.write_new) begin
      hop_next = hop_in;
    end else if (ctl.take_left) begin
      hop_next = left_hop;
    end else if (ctl.take_right) begin
      hop_next = right_hop;
    end else begin
      hop_next = hop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop <= '0;
    end else begin
      hop <= hop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr) begin
      load_hop <= hop_in;
    end
  end

endmodule
